// ----- src/bmdp_pkg.sv -----
package bmdp_pkg;

	localparam int SIZE  = 32;
	localparam int IDX_W = 5;
	localparam int CNT_W = 6;
	localparam int EDG_W = 11;
	localparam int POT_W = 12;

	typedef enum logic [1:0] {
		MODE_START   = 2'd0,
		MODE_LOAD    = 2'd1,
		MODE_DEL_ROW = 2'd2,
		MODE_DEL_COL = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE_A,
		ST_PRE_B,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [SIZE-1:0]  bits;
		logic [CNT_W-1:0] sum;
	} row_entry_t;

	function automatic logic [CNT_W-1:0] popcount(input logic [SIZE-1:0] v);
		logic [CNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < SIZE; i++) begin
			c = c + CNT_W'(v[i]);
		end
		return c;
	endfunction

endpackage

// ----- src/bipartite_min_degree_peeling.sv -----
// Greedy minimum-degree peeling over a bipartite 0/1 matrix of up to 32 rows by 32 columns.
// Each item selects an operation in s_tuser: start a matrix, load one row, remove the
// minimum-degree row, or remove the minimum-degree column; each item gives one result
// with the edge count, the sizes in use, both lowest-index minima and the potential.
// Rows and their sums live in one memory and column sums in another, both with a
// registered read; every operation that is not skipped ends in a read-modify-write
// pass over all 32 slots. A load outside the rows or a removal from an empty side is
// skipped and goes straight to its result. After reset a start pass with no rows or
// columns clears all row bits and sets every sum to 32 before the block takes an item.
module bipartite_min_degree_peeling (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// row_total[5:0], col_total[11:6], row_index[16:12], row_bits[48:17], zero fill
	input  logic [55:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// edge_count[10:0], rows_now[16:11], cols_now[22:17], min_row_index[27:23],
	// min_row_sum[33:28], min_col_index[38:34], min_col_sum[44:39], potential[56:45],
	// status[57], zero fill
	output logic [63:0] m_tdata
);
	import bmdp_pkg::*;

	row_entry_t       mat_mem [SIZE];
	logic [CNT_W-1:0] csum_mem [SIZE];
	row_entry_t       mat_rd;
	logic [CNT_W-1:0] cs_rd;

	state_t           state_q, state_nx;
	mode_t            op_q, in_mode;
	logic             emit_q, status_q;
	logic [CNT_W-1:0] rows_q, cols_q, idx_q;
	logic [EDG_W-1:0] edges_q;
	logic [IDX_W-1:0] least_row_q, least_col_q, a_idx_q, b_idx_q;
	logic [CNT_W-1:0] rmin_q, cmin_q, npop_q;
	logic [SIZE-1:0]  newbits_q;
	row_entry_t       a_row_q, b_row_q;
	logic [CNT_W-1:0] a_cs_q, b_cs_q;
	logic             vld_s1;
	logic [IDX_W-1:0] k_s1;
	logic             m_tvalid_q;
	logic [63:0]      m_tdata_q;

	logic [CNT_W-1:0] in_rows, in_cols;
	logic [IDX_W-1:0] in_ridx;
	logic [SIZE-1:0]  in_bits, in_mask;
	logic             accept, skip;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	row_entry_t       row_new;
	logic [CNT_W-1:0] col_new;
	logic [SIZE-1:0]  nb;
	logic             last_k, out_load;
	logic [POT_W-1:0] pot;

	assign in_mode = mode_t'(s_tuser);
	assign in_rows = s_tdata[5:0];
	assign in_cols = s_tdata[11:6];
	assign in_ridx = s_tdata[16:12];
	assign in_bits = s_tdata[48:17];
	assign in_mask = (cols_q >= CNT_W'(SIZE)) ? '1 : ((SIZE'(1) << cols_q) - SIZE'(1));
	assign accept  = s_tready && s_tvalid;
	assign last_k  = vld_s1 && (k_s1 == IDX_W'(SIZE - 1));
	assign out_load = (state_q == ST_FINISH) && emit_q && (!m_tvalid_q || m_tready);

	always_comb begin
		case (in_mode)
			MODE_LOAD:    skip = (CNT_W'(in_ridx) >= rows_q);
			MODE_DEL_ROW: skip = (rows_q == '0);
			MODE_DEL_COL: skip = (cols_q == '0);
			default:      skip = 1'b0;
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (skip)
						state_nx = ST_FINISH;
					else if (in_mode == MODE_START)
						state_nx = ST_SWEEP;
					else
						state_nx = ST_PRE_A;
				end
			end
			ST_PRE_A: state_nx = ST_PRE_B;
			ST_PRE_B: state_nx = ST_SWEEP;
			ST_SWEEP: begin
				if (last_k)
					state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				if (!emit_q || !m_tvalid_q || m_tready)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		rd_en    = 1'b0;
		rd_addr  = idx_q[IDX_W-1:0];
		case (state_q)
			ST_PRE_A: begin
				rd_en   = 1'b1;
				rd_addr = a_idx_q;
			end
			ST_PRE_B: begin
				rd_en   = 1'b1;
				rd_addr = b_idx_q;
			end
			ST_SWEEP: rd_en = (idx_q < CNT_W'(SIZE));
			default: rd_en = 1'b0;
		endcase
	end

	always_comb begin
		row_new = mat_rd;
		col_new = cs_rd;
		nb      = mat_rd.bits;
		case (op_q)
			MODE_START: begin
				row_new.bits = '0;
				row_new.sum  = (CNT_W'(k_s1) < rows_q) ? '0 : CNT_W'(SIZE);
				col_new      = (CNT_W'(k_s1) < cols_q) ? '0 : CNT_W'(SIZE);
			end
			MODE_LOAD: begin
				col_new = cs_rd - CNT_W'(a_row_q.bits[k_s1]) + CNT_W'(newbits_q[k_s1]);
				if (k_s1 == a_idx_q) begin
					row_new.bits = newbits_q;
					row_new.sum  = npop_q;
				end
			end
			MODE_DEL_ROW: begin
				col_new = cs_rd - CNT_W'(a_row_q.bits[k_s1]);
				if (k_s1 == b_idx_q) begin
					row_new.bits = '0;
					row_new.sum  = CNT_W'(SIZE);
				end else if (k_s1 == a_idx_q) begin
					row_new = b_row_q;
				end
			end
			default: begin
				nb[a_idx_q]  = mat_rd.bits[b_idx_q];
				nb[b_idx_q]  = 1'b0;
				row_new.bits = nb;
				row_new.sum  = mat_rd.sum - CNT_W'(mat_rd.bits[a_idx_q]);
				if (k_s1 == b_idx_q)
					col_new = CNT_W'(SIZE);
				else if (k_s1 == a_idx_q)
					col_new = b_cs_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mat_rd <= mat_mem[rd_addr];
			cs_rd  <= csum_mem[rd_addr];
		end
		if (vld_s1) begin
			mat_mem[k_s1]  <= row_new;
			csum_mem[k_s1] <= col_new;
		end
	end

	assign pot = POT_W'(edges_q) - POT_W'(rmin_q) - POT_W'(cmin_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			op_q        <= MODE_START;
			emit_q      <= 1'b0;
			status_q    <= 1'b0;
			rows_q      <= '0;
			cols_q      <= '0;
			idx_q       <= '0;
			edges_q     <= '0;
			least_row_q <= '0;
			least_col_q <= '0;
			a_idx_q     <= '0;
			b_idx_q     <= '0;
			rmin_q      <= CNT_W'(SIZE);
			cmin_q      <= CNT_W'(SIZE);
			vld_s1      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			vld_s1  <= (state_q == ST_SWEEP) && rd_en;
			if (state_q == ST_SWEEP && rd_en)
				idx_q <= idx_q + CNT_W'(1);
			if (state_q != ST_SWEEP)
				idx_q <= '0;
			if (accept) begin
				op_q     <= in_mode;
				emit_q   <= 1'b1;
				status_q <= skip && (in_mode == MODE_DEL_ROW || in_mode == MODE_DEL_COL);
				case (in_mode)
					MODE_START: begin
						rows_q  <= (in_rows > CNT_W'(SIZE)) ? CNT_W'(SIZE) : in_rows;
						cols_q  <= (in_cols > CNT_W'(SIZE)) ? CNT_W'(SIZE) : in_cols;
						edges_q <= '0;
					end
					MODE_LOAD: a_idx_q <= in_ridx;
					MODE_DEL_ROW: begin
						if (!skip) begin
							rows_q  <= rows_q - CNT_W'(1);
							a_idx_q <= least_row_q;
							b_idx_q <= IDX_W'(rows_q - CNT_W'(1));
						end
					end
					default: begin
						if (!skip) begin
							cols_q  <= cols_q - CNT_W'(1);
							a_idx_q <= least_col_q;
							b_idx_q <= IDX_W'(cols_q - CNT_W'(1));
						end
					end
				endcase
			end
			if (vld_s1) begin
				if (k_s1 == '0 || row_new.sum < rmin_q) begin
					rmin_q      <= row_new.sum;
					least_row_q <= k_s1;
				end
				if (k_s1 == '0 || col_new < cmin_q) begin
					cmin_q      <= col_new;
					least_col_q <= k_s1;
				end
			end
			if (last_k) begin
				case (op_q)
					MODE_LOAD:    edges_q <= edges_q - EDG_W'(a_row_q.sum) + EDG_W'(npop_q);
					MODE_DEL_ROW: edges_q <= edges_q - EDG_W'(a_row_q.sum);
					MODE_DEL_COL: edges_q <= edges_q - EDG_W'(a_cs_q);
					default:      edges_q <= edges_q;
				endcase
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= idx_q[IDX_W-1:0];
		if (accept) begin
			newbits_q <= in_bits & in_mask;
			npop_q    <= popcount(in_bits & in_mask);
		end
		if (state_q == ST_PRE_B) begin
			a_row_q <= mat_rd;
			a_cs_q  <= cs_rd;
		end
		if (state_q == ST_SWEEP && idx_q == '0) begin
			b_row_q <= mat_rd;
			b_cs_q  <= cs_rd;
		end
		if (out_load) begin
			m_tdata_q <= {6'd0, status_q, pot, cmin_q, least_col_q, rmin_q, least_row_q,
				cols_q, rows_q, edges_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !vld_s1)
		else $error("item taken while a pass is running");

	a_s1_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> state_q == ST_SWEEP)
		else $error("memory write outside a pass");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("result not presented");

	a_dims_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= CNT_W'(SIZE) && cols_q <= CNT_W'(SIZE))
		else $error("dimension beyond matrix size");

endmodule

// ----- dv/tb_bipartite_min_degree_peeling.sv -----
`timescale 1ns / 100ps

module tb_bipartite_min_degree_peeling;
	import bmdp_pkg::*;

	typedef struct packed {
		logic        status;
		logic [11:0] potential;
		logic [5:0]  min_col_sum;
		logic [4:0]  min_col_index;
		logic [5:0]  min_row_sum;
		logic [4:0]  min_row_index;
		logic [5:0]  cols_now;
		logic [5:0]  rows_now;
		logic [10:0] edge_count;
	} peel_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;

	logic [31:0] adj_rows [SIZE];
	int          row_deg [SIZE];
	int          col_deg [SIZE];
	int          edges_live;
	int          rows_live;
	int          cols_live;
	int          low_row;
	int          low_col;

	peel_result_t expected_results[$];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          fail_count;
	longint      cycle_count;

	bipartite_min_degree_peeling u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic int ones(input logic [31:0] v);
		int c;
		c = 0;
		for (int i = 0; i < 32; i++) begin
			c += v[i];
		end
		return c;
	endfunction

	function automatic void rescan_minima();
		low_row = 0;
		low_col = 0;
		for (int i = 1; i < SIZE; i++) begin
			if (row_deg[i] < row_deg[low_row]) begin
				low_row = i;
			end
			if (col_deg[i] < col_deg[low_col]) begin
				low_col = i;
			end
		end
	endfunction

	function automatic peel_result_t predict_peel(input mode_t mode, input int rtot,
			input int ctot, input int ridx, input logic [31:0] bits);
		peel_result_t r;
		logic [31:0] gone;
		logic        a, b;
		int          last, tsum;
		int          pot;
		r.status = 1'b0;
		case (mode)
			MODE_START: begin
				rows_live = rtot > SIZE ? SIZE : rtot;
				cols_live = ctot > SIZE ? SIZE : ctot;
				edges_live = 0;
				for (int i = 0; i < SIZE; i++) begin
					adj_rows[i] = '0;
					row_deg[i] = i < rows_live ? 0 : SIZE;
					col_deg[i] = i < cols_live ? 0 : SIZE;
				end
				rescan_minima();
			end
			MODE_LOAD: begin
				if (ridx < rows_live) begin
					for (int j = 0; j < SIZE; j++) begin
						if (j >= cols_live) begin
							bits[j] = 1'b0;
						end
					end
					for (int j = 0; j < cols_live; j++) begin
						col_deg[j] = col_deg[j] - adj_rows[ridx][j] + bits[j];
					end
					edges_live = edges_live - ones(adj_rows[ridx]) + ones(bits);
					adj_rows[ridx] = bits;
					row_deg[ridx] = ones(bits);
					rescan_minima();
				end
			end
			MODE_DEL_ROW: begin
				if (rows_live == 0) begin
					r.status = 1'b1;
				end else begin
					rows_live--;
					last = rows_live;
					edges_live -= row_deg[low_row];
					if (low_row != last) begin
						gone = adj_rows[low_row];
						adj_rows[low_row] = adj_rows[last];
						adj_rows[last] = gone;
						tsum = row_deg[low_row];
						row_deg[low_row] = row_deg[last];
						row_deg[last] = tsum;
					end
					gone = adj_rows[last];
					adj_rows[last] = '0;
					row_deg[last] = SIZE;
					for (int j = 0; j < SIZE; j++) begin
						col_deg[j] -= gone[j];
					end
					rescan_minima();
				end
			end
			default: begin
				if (cols_live == 0) begin
					r.status = 1'b1;
				end else begin
					cols_live--;
					last = cols_live;
					edges_live -= col_deg[low_col];
					for (int i = 0; i < SIZE; i++) begin
						if (low_col != last) begin
							a = adj_rows[i][low_col];
							b = adj_rows[i][last];
							adj_rows[i][low_col] = b;
							adj_rows[i][last] = a;
						end
						if (adj_rows[i][last]) begin
							row_deg[i]--;
							adj_rows[i][last] = 1'b0;
						end
					end
					if (low_col != last) begin
						tsum = col_deg[low_col];
						col_deg[low_col] = col_deg[last];
						col_deg[last] = tsum;
					end
					col_deg[last] = SIZE;
					rescan_minima();
				end
			end
		endcase
		pot = edges_live - row_deg[low_row] - col_deg[low_col];
		r.edge_count = 11'(edges_live);
		r.rows_now = 6'(rows_live);
		r.cols_now = 6'(cols_live);
		r.min_row_index = 5'(low_row);
		r.min_row_sum = 6'(row_deg[low_row]);
		r.min_col_index = 5'(low_col);
		r.min_col_sum = 6'(col_deg[low_col]);
		r.potential = 12'(pot);
		return r;
	endfunction

	task automatic send_item(input mode_t mode, input int rtot, input int ctot,
			input int ridx, input logic [31:0] bits);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {7'b0, bits, 5'(ridx), 6'(ctot), 6'(rtot)};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		expected_results.push_back(predict_peel(mode, rtot, ctot, ridx, bits));
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (40) @(negedge clk);
	endtask

	task automatic random_matrix_session(input int rtot, input int ctot, input int peels);
		send_item(MODE_START, rtot, ctot, $urandom_range(31), $urandom);
		for (int r = 0; r < 32; r++) begin
			if (r < rtot || $urandom_range(9) == 0) begin
				send_item(MODE_LOAD, $urandom_range(63), $urandom_range(63), r,
					$urandom_range(3) == 0 ? $urandom & $urandom : $urandom);
			end
		end
		for (int k = 0; k < peels; k++) begin
			send_item($urandom_range(1) ? MODE_DEL_ROW : MODE_DEL_COL,
				$urandom_range(63), $urandom_range(63), $urandom_range(31), $urandom);
		end
	endtask

	task automatic test_directed();
		send_item(MODE_DEL_ROW, 0, 0, 0, '0);
		send_item(MODE_DEL_COL, 63, 63, 31, '1);
		send_item(MODE_START, 63, 40, 0, '1);
		send_item(MODE_LOAD, 0, 0, 0, '1);
		send_item(MODE_LOAD, 0, 0, 31, 32'h5555_5555);
		send_item(MODE_LOAD, 0, 0, 31, 32'hAAAA_AAAA);
		send_item(MODE_LOAD, 0, 0, 5, 32'h0000_00FF);
		send_item(MODE_DEL_COL, 0, 0, 0, '0);
		send_item(MODE_DEL_ROW, 0, 0, 0, '0);
		send_item(MODE_START, 3, 5, 0, '0);
		send_item(MODE_LOAD, 0, 0, 3, '1);
		send_item(MODE_LOAD, 0, 0, 1, '1);
		send_item(MODE_LOAD, 0, 0, 0, 32'h0000_0005);
		send_item(MODE_LOAD, 0, 0, 2, 32'h0000_0003);
		send_item(MODE_DEL_ROW, 0, 0, 0, '0);
		send_item(MODE_DEL_COL, 0, 0, 0, '0);
		send_item(MODE_DEL_ROW, 0, 0, 0, '0);
		send_item(MODE_DEL_ROW, 0, 0, 0, '0);
		send_item(MODE_DEL_ROW, 0, 0, 0, '0);
		send_item(MODE_DEL_COL, 0, 0, 0, '0);
		send_item(MODE_START, 0, 0, 0, '0);
		send_item(MODE_LOAD, 0, 0, 0, '1);
		send_item(MODE_DEL_COL, 0, 0, 0, '0);
		drain();
	endtask

	task automatic test_random_phase(input int idle, input int stall, input int sessions);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		for (int s = 0; s < sessions; s++) begin
			if (s % 4 == 3) begin
				random_matrix_session(32, 32, 10);
			end else begin
				random_matrix_session($urandom_range(10), $urandom_range(10),
					$urandom_range(4, 16));
			end
			if (s == 1) begin
				drain();
			end
		end
		drain();
	endtask

	task automatic test_noise();
		for (int k = 0; k < 40; k++) begin
			send_item(mode_t'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
				$urandom_range(31), $urandom);
		end
		drain();
	endtask

	always @(posedge clk) begin
		peel_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = peel_result_t'(m_tdata[57:0]);
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result %h", $realtime, m_tdata);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got !== want || m_tdata[63:58] !== 6'b0) begin
					$display("%0t mismatch expected %p actual %p", $realtime, want, got);
					fail_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_START;
		m_tready = 1'b1;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		cycle_count = 0;
		void'(predict_peel(MODE_START, 0, 0, 0, '0));
		for (int i = 0; i < SIZE; i++) begin
			row_deg[i] = SIZE;
			col_deg[i] = SIZE;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_phase(0, 0, 6);
		test_random_phase(61, 0, 5);
		test_random_phase(0, 61, 5);
		test_random_phase(35, 35, 5);
		test_noise();
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
